// ===== rtl/core/tfp_pkg.sv =====
package tfp_pkg;

  localparam int BYTE_W     = 8;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_USER_W = 2;
  localparam int OUT_DATA_W = 160;

  localparam logic [BYTE_W-1:0] HDR0 = 8'h57;
  localparam logic [BYTE_W-1:0] HDR1 = 8'h00;
  localparam logic [BYTE_W-1:0] HDR2 = 8'hFF;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam int POS_ID     = 3;
  localparam int POS_TIME0  = 4;
  localparam int POS_DIST0  = 8;
  localparam int POS_STATUS = 11;
  localparam int POS_STR0   = 12;

  localparam int MAXD_W     = 23;
  localparam int TMO_W      = 16;
  localparam int AGE_W      = 16;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_ADDR_W-1:0] REG_MAX_DIST = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT  = 1'd1;

  localparam logic [MAXD_W-1:0] MAXD_RST = 23'd5000;
  localparam logic [TMO_W-1:0]  TMO_RST  = 16'd250;
  localparam logic [AGE_W-1:0]  AGE_TOP  = 16'hFFFF;

  typedef logic [1:0] cmd_kind_t;
  localparam cmd_kind_t CMD_BYTE = 2'd0;
  localparam cmd_kind_t CMD_TICK = 2'd1;
  localparam cmd_kind_t CMD_GOOD = 2'd2;
  localparam cmd_kind_t CMD_BAD  = 2'd3;

  typedef logic [1:0] frame_event_t;
  localparam frame_event_t EV_NONE = 2'd0;
  localparam frame_event_t EV_GOOD = 2'd1;
  localparam frame_event_t EV_BAD  = 2'd2;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [7:0]         sensor_id;
    logic [31:0]        sensor_time;
    logic signed [23:0] distance;
    logic [7:0]         status;
    logic [15:0]        strength;
  } frame_cmd_t;

endpackage

// ===== rtl/core/tfp_front.sv =====
module tfp_front #(
  parameter int FRAME_LENGTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic                         operation,
  input  logic [tfp_pkg::BYTE_W-1:0]   data_byte,
  output logic                         push,
  output tfp_pkg::frame_cmd_t          cmd
);
  import tfp_pkg::*;

  localparam int POS_W = $clog2(FRAME_LENGTH);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LENGTH - 1);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [7:0]        id_r;
  logic [31:0]       time_r;
  logic [23:0]       dist_r;
  logic [7:0]        status_r;
  logic [15:0]       str_r;
  cmd_kind_t         kind;
  logic              restart;

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    kind    = CMD_BYTE;
    restart = 1'b0;
    if (operation == OP_TICK) begin
      kind = CMD_TICK;
    end else begin
      unique case (pos_r)
        POS_W'(0): begin
          restart = 1'b1;
        end
        POS_W'(1): begin
          if (data_byte == HDR1) begin
            pos_nxt = POS_W'(2);
            sum_nxt = sum_r + data_byte;
          end else begin
            restart = 1'b1;
          end
        end
        POS_W'(2): begin
          if (data_byte == HDR2) begin
            pos_nxt = POS_W'(3);
            sum_nxt = sum_r + data_byte;
          end else begin
            restart = 1'b1;
          end
        end
        default: begin
          if (pos_r == LAST_POS) begin
            kind    = (sum_r == data_byte) ? CMD_GOOD : CMD_BAD;
            pos_nxt = '0;
            sum_nxt = '0;
          end else begin
            pos_nxt = pos_r + POS_W'(1);
            sum_nxt = sum_r + data_byte;
          end
        end
      endcase
      if (restart) begin
        if (data_byte == HDR0) begin
          pos_nxt = POS_W'(1);
          sum_nxt = data_byte;
        end else begin
          pos_nxt = '0;
          sum_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  // The payload bytes land in their fields as they arrive.
  always_ff @(posedge clk) begin
    if (accept && operation == OP_BYTE) begin
      case (pos_r)
        POS_W'(POS_ID):        id_r          <= data_byte;
        POS_W'(POS_TIME0):     time_r[7:0]   <= data_byte;
        POS_W'(POS_TIME0 + 1): time_r[15:8]  <= data_byte;
        POS_W'(POS_TIME0 + 2): time_r[23:16] <= data_byte;
        POS_W'(POS_TIME0 + 3): time_r[31:24] <= data_byte;
        POS_W'(POS_DIST0):     dist_r[7:0]   <= data_byte;
        POS_W'(POS_DIST0 + 1): dist_r[15:8]  <= data_byte;
        POS_W'(POS_DIST0 + 2): dist_r[23:16] <= data_byte;
        POS_W'(POS_STATUS):    status_r      <= data_byte;
        POS_W'(POS_STR0):      str_r[7:0]    <= data_byte;
        POS_W'(POS_STR0 + 1):  str_r[15:8]   <= data_byte;
        default: ;
      endcase
    end
  end

  assign push             = accept;
  assign cmd.kind         = kind;
  assign cmd.sensor_id    = id_r;
  assign cmd.sensor_time  = time_r;
  assign cmd.distance     = dist_r;
  assign cmd.status       = status_r;
  assign cmd.strength     = str_r;

endmodule

// ===== rtl/core/tfp_cmd_queue.sv =====
module tfp_cmd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tfp_pkg::frame_cmd_t push_cmd,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output tfp_pkg::frame_cmd_t pop_cmd
);
  import tfp_pkg::*;

  frame_cmd_t slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign full      = count_r[1];
  assign not_empty = (count_r != 2'd0);
  assign pop_cmd   = slot_r[rd_ptr_r];

endmodule

// ===== rtl/core/tfp_back.sv =====
module tfp_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tfp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [tfp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              cmd_valid,
  input  tfp_pkg::frame_cmd_t               cmd,
  output logic                              cmd_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tfp_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [tfp_pkg::OUT_USER_W-1:0]    out_tuser
);
  import tfp_pkg::*;

  logic [MAXD_W-1:0]  max_dist_r;
  logic [TMO_W-1:0]   timeout_r;
  logic               out_valid_r;
  frame_event_t       event_r, event_nxt;
  logic [7:0]         id_r;
  logic [31:0]        time_r;
  logic signed [23:0] dist_r;
  logic [7:0]         status_r;
  logic [15:0]        str_r;
  logic               valid_r, valid_nxt;
  logic [31:0]        good_r;
  logic [31:0]        bad_r;
  logic [AGE_W-1:0]   age_r, age_nxt;
  logic               stale_r, stale_nxt;
  logic               in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r <= MAXD_RST;
      timeout_r  <= TMO_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAX_DIST: max_dist_r <= cfg_wdata[MAXD_W-1:0];
        REG_TIMEOUT:  timeout_r  <= cfg_wdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  assign cmd_pop  = cmd_valid && (!out_valid_r || out_tready);
  assign in_range = !cmd.distance[23] && (cmd.distance[22:0] <= max_dist_r) &&
                    (cmd.strength != 16'd0);

  always_comb begin
    age_nxt   = age_r;
    valid_nxt = valid_r;
    event_nxt = EV_NONE;
    unique case (cmd.kind)
      CMD_TICK: begin
        if (age_r != AGE_TOP) begin
          age_nxt = age_r + AGE_W'(1);
        end
      end
      CMD_GOOD: begin
        age_nxt   = '0;
        valid_nxt = in_range;
        event_nxt = EV_GOOD;
      end
      CMD_BAD: begin
        event_nxt = EV_BAD;
      end
      default: ;
    endcase
    stale_nxt = (age_nxt > timeout_r);
    if (stale_nxt) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      event_r     <= EV_NONE;
      id_r        <= '0;
      time_r      <= '0;
      dist_r      <= '0;
      status_r    <= '0;
      str_r       <= '0;
      valid_r     <= 1'b0;
      good_r      <= '0;
      bad_r       <= '0;
      age_r       <= AGE_TOP;
      stale_r     <= 1'b0;
    end else begin
      if (cmd_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd_pop) begin
        event_r <= event_nxt;
        valid_r <= valid_nxt;
        age_r   <= age_nxt;
        stale_r <= stale_nxt;
        if (cmd.kind == CMD_GOOD) begin
          id_r     <= cmd.sensor_id;
          time_r   <= cmd.sensor_time;
          dist_r   <= cmd.distance;
          status_r <= cmd.status;
          str_r    <= cmd.strength;
          good_r   <= good_r + 32'd1;
        end
        if (cmd.kind == CMD_BAD) begin
          bad_r <= bad_r + 32'd1;
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = event_r;
  assign out_tdata  = {6'd0, stale_r, bad_r, good_r, valid_r, str_r, status_r,
                       dist_r, time_r, id_r};

  a_good_clears_age: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop && cmd.kind == CMD_GOOD |=> age_r == '0 && event_r == EV_GOOD)
    else $error("good frame did not restart the data age");

  a_valid_not_stale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(valid_r && stale_r))
    else $error("distance marked valid while data is stale");

  a_bad_counts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop && cmd.kind == CMD_BAD |=> bad_r == $past(bad_r) + 32'd1 &&
    good_r == $past(good_r))
    else $error("checksum error not counted exactly once");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> $stable(good_r) && $stable(age_r))
    else $error("state changed while a result was waiting");

endmodule

// ===== rtl/core/tof_frame_parser_top.sv =====
// Time-of-flight sensor frame parser. Each input word is a received UART byte
// or a one-millisecond tick, and every input word yields exactly one result
// word carrying the frame event and the fields of the last good frame. The
// block sustains one word per clock cycle in both directions while out_tready
// stays high; a result word passes through the command queue and then the
// output register. The front parser tracks the header, byte position and a
// running checksum, a two-entry queue holds its commands, and the back end
// updates counters, data age and the valid flag into the output register.
// Configuration writes are expected only while no word is in flight.
module tof_frame_parser_top #(
  parameter int FRAME_LENGTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tfp_pkg::IN_TDATA_W-1:0]    in_tdata,   // data_byte
  input  logic                              in_tuser,   // operation
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // sensor_id, sensor_time, distance_mm, status byte, signal_strength,
  // distance_valid, frames_good, frames_bad, data_stale, zero fill
  output logic [tfp_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [tfp_pkg::OUT_USER_W-1:0]    out_tuser,  // frame_event
  input  logic                              cfg_we,
  input  logic [tfp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [tfp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tfp_pkg::*;

  logic       accept;
  logic       push;
  logic       full;
  logic       pop;
  logic       not_empty;
  frame_cmd_t push_cmd;
  frame_cmd_t pop_cmd;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  tfp_front #(
    .FRAME_LENGTH(FRAME_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .operation (in_tuser),
    .data_byte (in_tdata),
    .push      (push),
    .cmd       (push_cmd)
  );

  tfp_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_cmd   (pop_cmd)
  );

  tfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd_valid  (not_empty),
    .cmd        (pop_cmd),
    .cmd_pop    (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== sim/tof_frame_parser_top_test.sv =====
`timescale 1ns / 100ps

module tof_frame_parser_top_test;
  import tfp_pkg::*;

  localparam int FRAME_LEN   = 16;
  localparam int PHASE_WORDS = 290;
  localparam int LIMIT       = 500000;

  typedef struct packed {
    frame_event_t       ev;
    logic [7:0]         sensor_id;
    logic [31:0]        sensor_time;
    logic [23:0]        distance;
    logic [7:0]         status;
    logic [15:0]        strength;
    logic               valid;
    logic [31:0]        good;
    logic [31:0]        bad;
    logic               stale;
  } result_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       typed;
    result_t    res;
  } step_row_t;

  localparam result_t BLANK = '{EV_NONE, 8'h00, 32'h0, 24'd0, 8'h00, 16'h0,
                                1'b0, 32'd0, 32'd0, 1'b1};
  localparam result_t FIRST_GOOD = '{EV_GOOD, 8'hA5, 32'hFFFF_FFFF, 24'd5000, 8'h00,
                                     16'h0001, 1'b1, 32'd1, 32'd0, 1'b0};

  // Header mismatches at the second and third byte, then a frame with the
  // distance exactly at the reset limit and a tick in the middle of it.
  localparam step_row_t STEPS [0:24] = '{
    '{OP_TICK, 8'h3C, 1'b1, BLANK},
    '{OP_BYTE, 8'h57, 1'b1, BLANK},
    '{OP_BYTE, 8'h33, 1'b1, BLANK},
    '{OP_BYTE, 8'h57, 1'b1, BLANK},
    '{OP_BYTE, 8'h57, 1'b0, BLANK},
    '{OP_BYTE, 8'h00, 1'b0, BLANK},
    '{OP_BYTE, 8'h57, 1'b0, BLANK},
    '{OP_BYTE, 8'h00, 1'b0, BLANK},
    '{OP_BYTE, 8'hFF, 1'b0, BLANK},
    '{OP_BYTE, 8'hA5, 1'b0, BLANK},
    '{OP_BYTE, 8'hFF, 1'b0, BLANK},
    '{OP_BYTE, 8'hFF, 1'b0, BLANK},
    '{OP_BYTE, 8'hFF, 1'b0, BLANK},
    '{OP_BYTE, 8'hFF, 1'b0, BLANK},
    '{OP_BYTE, 8'h88, 1'b0, BLANK},
    '{OP_BYTE, 8'h13, 1'b0, BLANK},
    '{OP_BYTE, 8'h00, 1'b0, BLANK},
    '{OP_BYTE, 8'h00, 1'b0, BLANK},
    '{OP_BYTE, 8'h01, 1'b0, BLANK},
    '{OP_BYTE, 8'h00, 1'b0, BLANK},
    '{OP_TICK, 8'hC3, 1'b1, BLANK},
    '{OP_BYTE, 8'hFF, 1'b0, BLANK},
    '{OP_BYTE, 8'h92, 1'b1, FIRST_GOOD},
    '{OP_TICK, 8'h00, 1'b0, BLANK},
    '{OP_BYTE, 8'h57, 1'b0, BLANK}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  tof_frame_parser_top #(.FRAME_LENGTH(FRAME_LEN)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Parser state as the block should hold it.
  logic [MAXD_W-1:0] lim_dist = MAXD_RST;
  logic [TMO_W-1:0]  lim_age = TMO_RST;
  logic [7:0]        frame [FRAME_LEN];
  int                pos = 0;
  logic [7:0]        held_id = '0;
  logic [31:0]       held_time = '0;
  logic [23:0]       held_dist = '0;
  logic [7:0]        held_status = '0;
  logic [15:0]       held_strength = '0;
  logic              valid_now = 1'b0;
  logic [31:0]       good_total = '0;
  logic [31:0]       bad_total = '0;
  logic [AGE_W-1:0]  age = AGE_TOP;

  result_t expected_q [$];
  int      words_sent = 0;
  int      fail_cnt = 0;
  int      cycles = 0;
  int      seen_good = 0;
  int      seen_bad = 0;
  int      seen_stale = 0;
  bit      send_calm = 1'b0;
  bit      recv_calm = 1'b0;

  function automatic result_t predict_word(input logic op, input logic [7:0] b);
    result_t    r;
    logic [7:0] want;
    logic [7:0] sum;
    r.ev = EV_NONE;
    if (op == OP_TICK) begin
      if (age != AGE_TOP) age = age + 1'b1;
    end else if (pos < 3) begin
      want = (pos == 0) ? HDR0 : (pos == 1) ? HDR1 : HDR2;
      if (b == want) begin
        frame[pos] = b;
        pos = pos + 1;
      end else if (b == HDR0) begin
        frame[0] = b;
        pos = 1;
      end else begin
        pos = 0;
      end
    end else begin
      frame[pos] = b;
      pos = pos + 1;
      if (pos == FRAME_LEN) begin
        pos = 0;
        sum = '0;
        for (int i = 0; i < FRAME_LEN - 1; i++) sum = sum + frame[i];
        if (sum != frame[FRAME_LEN-1]) begin
          bad_total = bad_total + 1;
          r.ev = EV_BAD;
        end else begin
          held_id = frame[POS_ID];
          held_time = {frame[POS_TIME0+3], frame[POS_TIME0+2], frame[POS_TIME0+1],
                       frame[POS_TIME0]};
          held_dist = {frame[POS_DIST0+2], frame[POS_DIST0+1], frame[POS_DIST0]};
          held_status = frame[POS_STATUS];
          held_strength = {frame[POS_STR0+1], frame[POS_STR0]};
          good_total = good_total + 1;
          age = '0;
          valid_now = !held_dist[23] && held_dist[22:0] <= lim_dist && held_strength != 0;
          r.ev = EV_GOOD;
        end
      end
    end
    r.stale = age > lim_age;
    if (r.stale) valid_now = 1'b0;
    r.sensor_id = held_id;
    r.sensor_time = held_time;
    r.distance = held_dist;
    r.status = held_status;
    r.strength = held_strength;
    r.valid = valid_now;
    r.good = good_total;
    r.bad = bad_total;
    return r;
  endfunction

  task automatic send_word(input logic op, input logic [7:0] b, input logic typed,
                           input result_t typed_res);
    int      gap;
    result_t guess;
    gap = send_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= op;
    do @(posedge clk); while (in_tready !== 1'b1);
    guess = predict_word(op, b);
    expected_q.push_back(typed ? typed_res : guess);
    words_sent++;
  endtask

  task automatic send_frame(input int upto, input bit corrupt);
    logic [7:0]  fb [FRAME_LEN];
    logic [23:0] range_mm;
    logic [7:0]  sum;
    fb[0] = HDR0;
    fb[1] = HDR1;
    fb[2] = HDR2;
    for (int i = 3; i < FRAME_LEN; i++) fb[i] = 8'($urandom);
    case ($urandom_range(0, 5))
      0: range_mm = {1'b0, lim_dist};
      1: range_mm = {1'b0, lim_dist} + 1'b1;
      2: range_mm = 24'h000000;
      3: range_mm = ($urandom_range(0, 1) != 0) ? 24'h800000 : 24'hFFFFFF;
      4: range_mm = 24'($urandom_range(0, lim_dist));
      default: range_mm = 24'($urandom);
    endcase
    {fb[POS_DIST0+2], fb[POS_DIST0+1], fb[POS_DIST0]} = range_mm;
    if ($urandom_range(0, 4) == 0) {fb[POS_STR0+1], fb[POS_STR0]} = 16'h0000;
    sum = '0;
    for (int i = 0; i < FRAME_LEN - 1; i++) sum = sum + fb[i];
    fb[FRAME_LEN-1] = corrupt ? sum + 8'($urandom_range(1, 255)) : sum;
    for (int i = 0; i < upto; i++) begin
      if ($urandom_range(0, 7) == 0) send_word(OP_TICK, 8'($urandom), 1'b0, BLANK);
      send_word(OP_BYTE, fb[i], 1'b0, BLANK);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(input logic [MAXD_W-1:0] maxd, input logic [TMO_W-1:0] tmo);
    cfg_we <= 1'b1;
    cfg_addr <= REG_MAX_DIST;
    cfg_wdata <= CFG_DATA_W'(maxd);
    @(posedge clk);
    cfg_addr <= REG_TIMEOUT;
    cfg_wdata <= CFG_DATA_W'(tmo);
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_dist = maxd;
    lim_age = tmo;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tof_frame_parser_top_test NOT OK");
      $finish;
    end
  end

  initial begin
    int      stall;
    result_t want;
    wait (rst_n === 1'b1);
    forever begin
      stall = recv_calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      if (expected_q.size() == 0) begin
        $error("result word with no expectation pending");
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        check_field("frame_event", want.ev, out_tuser);
        check_field("sensor_id", want.sensor_id, out_tdata[7:0]);
        check_field("sensor_time", want.sensor_time, out_tdata[39:8]);
        check_field("distance_mm", want.distance, out_tdata[63:40]);
        check_field("status_byte", want.status, out_tdata[71:64]);
        check_field("signal_strength", want.strength, out_tdata[87:72]);
        check_field("distance_valid", want.valid, out_tdata[88]);
        check_field("frames_good", want.good, out_tdata[120:89]);
        check_field("frames_bad", want.bad, out_tdata[152:121]);
        check_field("data_stale", want.stale, out_tdata[153]);
        if (want.ev == EV_GOOD) seen_good++;
        if (want.ev == EV_BAD) seen_bad++;
        if (want.stale) seen_stale++;
      end
    end
  end

  initial begin
    int         target;
    int         cap;
    int         n;
    logic [7:0] nb;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (STEPS[i]) send_word(STEPS[i].op, STEPS[i].data, STEPS[i].typed, STEPS[i].res);
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        1: load_config('0, '0);
        2: begin
          load_config({MAXD_W{1'b1}}, 16'd65534);
          send_calm = 1'b1;
          recv_calm = 1'b1;
        end
        3: begin
          load_config(MAXD_W'($urandom_range(1, 20000)), TMO_W'($urandom_range(2, 40)));
          recv_calm = 1'b0;
        end
        4: begin
          load_config(MAXD_W'(5000), TMO_W'(5));
          send_calm = 1'b0;
          recv_calm = 1'b1;
        end
        default: ;
      endcase
      cap = (lim_age < 60) ? lim_age + 3 : 6;
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        case ($urandom_range(0, 9))
          6: send_frame($urandom_range(1, FRAME_LEN - 1), 1'b0);
          7: begin
            n = $urandom_range(1, 6);
            repeat (n) begin
              case ($urandom_range(0, 3))
                0: nb = HDR0;
                1: nb = HDR1;
                2: nb = HDR2;
                default: nb = 8'($urandom);
              endcase
              send_word(OP_BYTE, nb, 1'b0, BLANK);
            end
          end
          8, 9: begin
            n = $urandom_range(1, cap);
            repeat (n) send_word(OP_TICK, 8'($urandom), 1'b0, BLANK);
          end
          default: send_frame(FRAME_LEN, $urandom_range(0, 4) == 0);
        endcase
      end
    end
    drain();
    $display("Sent %0d words under five register settings, limits at both extremes.",
             words_sent);
    $display("Checked %0d good frames, %0d checksum errors and %0d stale results.",
             seen_good, seen_bad, seen_stale);
    if (fail_cnt == 0) begin
      $display("tof_frame_parser_top_test OK");
    end else begin
      $display("tof_frame_parser_top_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tfp_pkg.sv
rtl/core/tfp_front.sv
rtl/core/tfp_cmd_queue.sv
rtl/core/tfp_back.sv
rtl/core/tof_frame_parser_top.sv
sim/tof_frame_parser_top_test.sv
